[hdl/b36a_pkg.sv]
// Shared types, constants and helper functions of the base-36 ASCII converter.
package b36a_pkg;

    localparam int VALUE_W   = 64;
    localparam int COUNT_W   = 4;
    localparam int CHUNK_W   = 16;
    localparam int REM_W     = 6;
    localparam int CHAR_W    = 7;
    localparam int CHUNKS    = VALUE_W / CHUNK_W;
    localparam int CHUNK_IW  = $clog2(CHUNKS);

    // Reciprocal of 9 scaled by 2**23, rounded up. For every 20-bit y the
    // product y * RECIP9 shifted right by RECIP_SH is exactly y / 9.
    localparam logic [19:0] RECIP9   = 20'd932068;
    localparam int          RECIP_SH = 23;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'd48;
    localparam logic [CHAR_W-1:0] ASCII_A    = 7'd65;
    localparam logic [REM_W-1:0]  DEC_DIGITS = 6'd10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic emit_start;
        logic emit;
    } b36a_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic value_ok;
        logic chunk_last;
        logic quot_zero_next;
        logic count_last;
        logic emit_last;
        logic out_free;
    } b36a_status_t;

    // Map a digit value 0..35 to its ASCII character.
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [REM_W-1:0] d);
        logic [CHAR_W-1:0] d7;
        d7 = {1'b0, d};
        if (d < DEC_DIGITS)
        begin
            return ASCII_ZERO + d7;
        end
        return ASCII_A + (d7 - {1'b0, DEC_DIGITS});
    endfunction

endpackage

[hdl/b36a_ctrl.sv]
// Controller state machine that sequences division steps and character output.
module b36a_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  b36a_pkg::b36a_status_t status,
    output b36a_pkg::b36a_cmd_t    cmd
);
    import b36a_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    if (status.value_ok)
                    begin
                        state_next = ST_DIVIDE;
                    end
                end
            end
            ST_DIVIDE:
            begin
                cmd.step = 1'b1;
                if (status.chunk_last && (status.quot_zero_next || status.count_last))
                begin
                    cmd.emit_start = 1'b1;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/b36a_dpath.sv]
// Datapath: chunked long division by 36, digit store and output register.
module b36a_dpath #(
    parameter int MAX_DIGITS = 13
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [b36a_pkg::VALUE_W-1:0]    value,
    input  b36a_pkg::b36a_cmd_t             cmd,
    output b36a_pkg::b36a_status_t          status,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [b36a_pkg::CHAR_W-1:0]     char_code,
    output logic                            last_char
);
    import b36a_pkg::*;

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    logic [VALUE_W-1:0]  quot_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [CHUNK_IW-1:0] chunk_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [REM_W-1:0]    store [MAX_DIGITS];
    logic                out_valid_reg;
    logic [CHAR_W-1:0]   out_char_reg;
    logic                out_last_reg;

    logic [CHUNK_W+REM_W-1:0] dividend;
    logic [19:0]              dividend_q;
    logic [39:0]              product;
    logic [CHUNK_W-1:0]       chunk_quot;
    logic [REM_W-1:0]         quot_times36_lo;
    logic [REM_W-1:0]         chunk_rem;
    logic [VALUE_W-1:0]       quot_shifted;

    // One 16-bit chunk of the long division: {rem, chunk} / 36 equals
    // ({rem, chunk} >> 2) / 9, found with a reciprocal multiply.
    assign dividend        = {rem_reg, quot_reg[VALUE_W-1 -: CHUNK_W]};
    assign dividend_q      = dividend[CHUNK_W+REM_W-1:2];
    assign product         = dividend_q * RECIP9;
    assign chunk_quot      = product[RECIP_SH +: CHUNK_W];
    // The remainder is below 36, so only the low six bits of 36 * q matter.
    assign quot_times36_lo = {chunk_quot[0], 5'b0} + {chunk_quot[3:0], 2'b0};
    assign chunk_rem       = dividend[REM_W-1:0] - quot_times36_lo;
    assign quot_shifted    = {quot_reg[VALUE_W-CHUNK_W-1:0], chunk_quot};

    assign status.value_ok       = !value[VALUE_W-1] && (value != '0);
    assign status.chunk_last     = (chunk_reg == CHUNK_IW'(CHUNKS - 1));
    assign status.quot_zero_next = (quot_shifted == '0);
    assign status.count_last     = (count_reg == COUNT_W'(MAX_DIGITS - 1));
    assign status.emit_last      = (idx_reg == '0);
    assign status.out_free       = !out_valid_reg || m_tready;

    assign m_tvalid  = out_valid_reg;
    assign char_code = out_char_reg;
    assign last_char = out_last_reg;

    // Division working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            quot_reg <= {1'b0, value[VALUE_W-2:0]};
            rem_reg  <= '0;
        end
        else if (cmd.step)
        begin
            quot_reg <= quot_shifted;
            rem_reg  <= status.chunk_last ? '0 : chunk_rem;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step && status.chunk_last)
        begin
            store[count_reg[IDX_W-1:0]] <= chunk_rem;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_char_reg <= digit_to_ascii(store[idx_reg]);
            out_last_reg <= status.emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_reg     <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                chunk_reg <= '0;
                count_reg <= '0;
            end
            else if (cmd.step)
            begin
                chunk_reg <= chunk_reg + 1'b1;
                if (status.chunk_last)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end

            // The digit just written sits at the old count, the most
            // significant one, so emission starts there.
            if (cmd.emit_start)
            begin
                idx_reg <= count_reg[IDX_W-1:0];
            end
            else if (cmd.emit)
            begin
                idx_reg <= idx_reg - 1'b1;
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

[hdl/binary_to_base36_ascii.sv]
// Top level of the signed 64-bit to base-36 ASCII string converter.
//
// Each input transaction carries one signed 64-bit number. A positive number
// produces its base-36 digits as ASCII characters ('0'-'9', 'A'-'Z'), most
// significant first and without leading zeros, one output transaction per
// character; the final character has tlast set. Zero or a negative number
// produces no output at all. One number is converted at a time: after the
// input transaction the digits are found by long division by 36, taking the
// 64-bit word in four 16-bit chunks through one reciprocal multiplier, one
// chunk per division step. The characters then leave at one per cycle
// while the output side is ready. A nonpositive number is dropped without
// leaving the idle state. The next number is accepted as soon as the last
// character has been placed in the output register, even if it has not yet
// been taken. With MAX_DIGITS below 13, only the MAX_DIGITS least
// significant digits of a longer number are emitted.
module binary_to_base36_ascii #(
    parameter int MAX_DIGITS = 13
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] value (signed)
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] char_code, [7] zero fill
    output logic        m_tlast    // last_char
);
    import b36a_pkg::*;

    b36a_cmd_t         cmd;
    b36a_status_t      status;
    logic [CHAR_W-1:0] char_code;

    b36a_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    b36a_dpath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .char_code (char_code),
        .last_char (m_tlast)
    );

    // The character occupies the low seven bits; the top bit is zero fill.
    assign m_tdata = {1'b0, char_code};

endmodule
